FILE: rtl/pbl_pkg.sv
package pbl_pkg;

	// default geometry
	localparam int COORD_BITS_DEF = 24;
	localparam int COUNT_BITS_DEF = 16;

	// accumulated length, unsigned Q32.8
	localparam int LEN_BITS = 40;

	// configuration port
	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam logic CFG_IDX_CLOSED_PATH = 1'b0;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_TOO_FEW = 2'd1,
		STATUS_LEN_SAT = 2'd2
	} pbl_status_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SQX,
		ST_SQY,
		ST_START,
		ST_ROOT,
		ST_ACC,
		ST_UPDATE,
		ST_EMIT
	} pbl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic seg_close;
		logic diff;
		logic sq_x;
		logic sq_y;
		logic root_start;
		logic acc;
		logic update;
		logic emit;
	} pbl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic first_pt;
		logic last_pt;
		logic root_busy;
		logic out_free;
	} pbl_stat_t;

endpackage

FILE: rtl/pbl_isqrt.sv
module pbl_isqrt #(
	parameter int RAD_BITS = 2 * pbl_pkg::COORD_BITS_DEF + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [RAD_BITS-1:0]   radicand,
	output logic                  busy,
	output logic [RAD_BITS/2-1:0] root
);
	import pbl_pkg::*;

	localparam int ROOT_BITS = RAD_BITS / 2;
	localparam int REM_BITS  = ROOT_BITS + 3;
	localparam int CNT_BITS  = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;

	logic [RAD_BITS-1:0]  rad_q;
	logic [REM_BITS-1:0]  rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;

	logic [REM_BITS-1:0]  rem_sh;
	logic [REM_BITS-1:0]  trial;
	logic                 take;

	// one root bit per cycle, restoring form
	always_comb begin
		rem_sh = {rem_q[REM_BITS-3:0], rad_q[RAD_BITS-1 -: 2]};
		trial  = REM_BITS'({root_q, 2'b01});
		take   = (rem_sh >= trial);
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(ROOT_BITS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// partial remainder and root
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_BITS-3:0], 2'b00};
			rem_q  <= take ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_BITS-2:0], take};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

FILE: rtl/pbl_dp.sv
module pbl_dp #(
	parameter int COORD_BITS = pbl_pkg::COORD_BITS_DEF,
	parameter int COUNT_BITS = pbl_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pbl_pkg::pbl_cmd_t             cmd,
	output pbl_pkg::pbl_stat_t            stat,
	input  logic                          closed_path,
	input  logic signed [COORD_BITS-1:0]  x_coord,
	input  logic signed [COORD_BITS-1:0]  y_coord,
	input  logic                          last_point,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic signed [COORD_BITS-1:0]  min_x,
	output logic signed [COORD_BITS-1:0]  min_y,
	output logic signed [COORD_BITS-1:0]  max_x,
	output logic signed [COORD_BITS-1:0]  max_y,
	output logic [pbl_pkg::LEN_BITS-1:0]  path_length,
	output logic [COUNT_BITS-1:0]         vertex_total,
	output logic [1:0]                    status
);
	import pbl_pkg::*;

	localparam int RAD_BITS  = 2 * COORD_BITS + 2;
	localparam int ROOT_BITS = COORD_BITS + 1;

	// current item and path state
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q;
	logic                         last_q;
	logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [COORD_BITS-1:0] low_x_q, low_y_q, high_x_q, high_y_q;
	logic [LEN_BITS-1:0]          len_q;
	logic [COUNT_BITS-1:0]        count_q;
	logic                         sat_q;

	// segment arithmetic
	logic signed [COORD_BITS-1:0] end_x, end_y;
	logic signed [COORD_BITS:0]   dx, dy;
	logic [COORD_BITS-1:0]        mag_x_q, mag_y_q;
	logic [COORD_BITS-1:0]        mul_in;
	logic [2*COORD_BITS-1:0]      sq_x_q, sq_y_q;
	logic [RAD_BITS-1:0]          radicand;
	logic                         root_busy;
	logic [ROOT_BITS-1:0]         root;
	logic [LEN_BITS:0]            len_sum;

	// output register
	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] min_x_q, min_y_q, max_x_q, max_y_q;
	logic [LEN_BITS-1:0]          path_length_q;
	logic [COUNT_BITS-1:0]        vertex_total_q;
	pbl_status_t                  status_q;
	pbl_status_t                  status_nxt;
	logic                         too_few;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_x_q <= x_coord;
			cur_y_q <= y_coord;
			last_q  <= last_point;
		end
	end

	// segment end point: current vertex, or first vertex for the closing edge
	always_comb begin
		end_x = cmd.seg_close ? first_x_q : cur_x_q;
		end_y = cmd.seg_close ? first_y_q : cur_y_q;
		dx    = (COORD_BITS+1)'(end_x) - (COORD_BITS+1)'(prev_x_q);
		dy    = (COORD_BITS+1)'(end_y) - (COORD_BITS+1)'(prev_y_q);
	end

	// absolute differences
	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			mag_x_q <= dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
			mag_y_q <= dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
		end
	end

	// one shared squarer, x magnitude then y magnitude
	assign mul_in = cmd.sq_y ? mag_y_q : mag_x_q;

	always_ff @(posedge clk) begin
		if (cmd.sq_x) begin
			sq_x_q <= mul_in * mul_in;
		end
		if (cmd.sq_y) begin
			sq_y_q <= mul_in * mul_in;
		end
	end

	assign radicand = RAD_BITS'(sq_x_q) + RAD_BITS'(sq_y_q);

	pbl_isqrt #(
		.RAD_BITS (RAD_BITS)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.root_start),
		.radicand (radicand),
		.busy     (root_busy),
		.root     (root)
	);

	assign len_sum = (LEN_BITS+1)'(len_q) + (LEN_BITS+1)'(root);

	// length accumulator, count and bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			count_q <= '0;
			sat_q   <= 1'b0;
		end else if (cmd.emit) begin
			len_q   <= '0;
			count_q <= '0;
			sat_q   <= 1'b0;
		end else begin
			if (cmd.acc) begin
				if (len_sum[LEN_BITS]) begin
					len_q <= '1;
					sat_q <= 1'b1;
				end else begin
					len_q <= len_sum[LEN_BITS-1:0];
				end
			end
			if (cmd.update && (count_q != '1)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			low_x_q   <= '0;
			low_y_q   <= '0;
			high_x_q  <= '0;
			high_y_q  <= '0;
		end else if (cmd.update) begin
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
			if (count_q == '0) begin
				first_x_q <= cur_x_q;
				first_y_q <= cur_y_q;
				low_x_q   <= cur_x_q;
				low_y_q   <= cur_y_q;
				high_x_q  <= cur_x_q;
				high_y_q  <= cur_y_q;
			end else begin
				if (cur_x_q < low_x_q)  low_x_q  <= cur_x_q;
				if (cur_x_q > high_x_q) high_x_q <= cur_x_q;
				if (cur_y_q < low_y_q)  low_y_q  <= cur_y_q;
				if (cur_y_q > high_y_q) high_y_q <= cur_y_q;
			end
		end
	end

	// result status, too few points wins over saturation
	always_comb begin
		too_few = closed_path ? (count_q < COUNT_BITS'(3)) : (count_q < COUNT_BITS'(2));
		if (too_few) begin
			status_nxt = STATUS_TOO_FEW;
		end else if (sat_q) begin
			status_nxt = STATUS_LEN_SAT;
		end else begin
			status_nxt = STATUS_OK;
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			min_x_q        <= low_x_q;
			min_y_q        <= low_y_q;
			max_x_q        <= high_x_q;
			max_y_q        <= high_y_q;
			path_length_q  <= len_q;
			vertex_total_q <= count_q;
			status_q       <= status_nxt;
		end
	end

	// status to controller
	always_comb begin
		stat.first_pt  = (count_q == '0);
		stat.last_pt   = last_q;
		stat.root_busy = root_busy;
		stat.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid    = out_valid_q;
	assign min_x        = min_x_q;
	assign min_y        = min_y_q;
	assign max_x        = max_x_q;
	assign max_y        = max_y_q;
	assign path_length  = path_length_q;
	assign vertex_total = vertex_total_q;
	assign status       = status_q;

endmodule

FILE: rtl/pbl_ctrl.sv
module pbl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               closed_path,
	input  pbl_pkg::pbl_stat_t stat,
	output pbl_pkg::pbl_cmd_t  cmd
);
	import pbl_pkg::*;

	pbl_state_t state_q, state_nxt;
	logic       closing_q;
	logic       accept;

	assign accept = (state_q == ST_IDLE) && in_valid;

	// state register and closing-edge flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			closing_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				closing_q <= 1'b0;
			end else if ((state_q == ST_UPDATE) && stat.last_pt && closed_path) begin
				closing_q <= 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = stat.first_pt ? ST_UPDATE : ST_DIFF;
				end
			end
			ST_DIFF:  state_nxt = ST_SQX;
			ST_SQX:   state_nxt = ST_SQY;
			ST_SQY:   state_nxt = ST_START;
			ST_START: state_nxt = ST_ROOT;
			ST_ROOT: begin
				if (!stat.root_busy) begin
					state_nxt = ST_ACC;
				end
			end
			ST_ACC: state_nxt = closing_q ? ST_EMIT : ST_UPDATE;
			ST_UPDATE: begin
				if (!stat.last_pt) begin
					state_nxt = ST_IDLE;
				end else if (closed_path) begin
					state_nxt = ST_DIFF;
				end else begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd           = '0;
		in_ready      = 1'b0;
		cmd.seg_close = closing_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIFF:   cmd.diff       = 1'b1;
			ST_SQX:    cmd.sq_x       = 1'b1;
			ST_SQY:    cmd.sq_y       = 1'b1;
			ST_START:  cmd.root_start = 1'b1;
			ST_ROOT:   cmd.acc        = 1'b0;
			ST_ACC:    cmd.acc        = 1'b1;
			ST_UPDATE: cmd.update     = 1'b1;
			ST_EMIT:   cmd.emit       = stat.out_free;
			default:   cmd.load       = 1'b0;
		endcase
	end

endmodule

FILE: rtl/path_bounds_and_length.sv
// Bounding box and length of a path of signed Q15.8 vertices.
// Input channel s_axis: one vertex per beat, x and y in tdata, tlast marks
// the final vertex. Output channel m_axis: one result beat per path with the
// box, the summed segment length, the vertex count and, in tuser, a status
// (ok, too few points, length saturated). Segment lengths are the truncated
// square root of dx*dx + dy*dy.
// APB register 0 bit 0 selects a closed polygon (reset 1) that also adds the
// edge from the last vertex back to the first; it is sampled at the final
// vertex. Write it only while the block is idle.
// Sequence: the first vertex of a path only sets the start point and the box.
// Every later vertex runs the difference, the squares of x and y and the
// restoring square root that resolves one root bit per cycle over
// COORD_BITS + 1 steps, then accumulates; no new vertex is taken before that.
// A closed path's final vertex runs these steps again for the closing edge;
// the result beat is registered in the emit state once the output is free.
// Reset clears the path state and the output valid flag. When the receiver
// stalls, a result waits in the output register; the block keeps taking
// vertices and only holds at the end of the next path until that beat is taken.
module path_bounds_and_length #(
	parameter int COORD_BITS = pbl_pkg::COORD_BITS_DEF,
	parameter int COUNT_BITS = pbl_pkg::COUNT_BITS_DEF
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	// slave stream
	input  logic                                           s_axis_tvalid,
	output logic                                           s_axis_tready,
	// x_coord, y_coord
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]              s_axis_tdata,
	input  logic                                           s_axis_tlast,
	// master stream
	output logic                                           m_axis_tvalid,
	input  logic                                           m_axis_tready,
	// min_x, min_y, max_x, max_y, path_length, vertex_total
	output logic [((4*COORD_BITS+pbl_pkg::LEN_BITS+COUNT_BITS+7)/8)*8-1:0] m_axis_tdata,
	// status
	output logic [1:0]                                     m_axis_tuser,
	// configuration
	input  logic                                           psel,
	input  logic                                           penable,
	input  logic                                           pwrite,
	input  logic [pbl_pkg::CFG_ADDR_BITS-1:0]              paddr,
	input  logic [pbl_pkg::CFG_DATA_BITS-1:0]              pwdata,
	output logic [pbl_pkg::CFG_DATA_BITS-1:0]              prdata,
	output logic                                           pready
);
	import pbl_pkg::*;

	localparam int OUT_RAW = 4 * COORD_BITS + LEN_BITS + COUNT_BITS;
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

	logic                         closed_path_q;
	pbl_cmd_t                     cmd;
	pbl_stat_t                    stat;
	logic signed [COORD_BITS-1:0] min_x, min_y, max_x, max_y;
	logic [LEN_BITS-1:0]          path_length;
	logic [COUNT_BITS-1:0]        vertex_total;
	logic [1:0]                   status;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_path_q <= 1'b1;
		end else if (psel && penable && pwrite && pready &&
			     (paddr[2] == CFG_IDX_CLOSED_PATH)) begin
			closed_path_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == CFG_IDX_CLOSED_PATH) ?
			CFG_DATA_BITS'(closed_path_q) : '0;

	pbl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.closed_path (closed_path_q),
		.stat        (stat),
		.cmd         (cmd)
	);

	pbl_dp #(
		.COORD_BITS (COORD_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.closed_path  (closed_path_q),
		.x_coord      (s_axis_tdata[COORD_BITS-1:0]),
		.y_coord      (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
		.last_point   (s_axis_tlast),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.min_x        (min_x),
		.min_y        (min_y),
		.max_x        (max_x),
		.max_y        (max_y),
		.path_length  (path_length),
		.vertex_total (vertex_total),
		.status       (status)
	);

	// pack the result beat, first field lowest
	assign m_axis_tdata = OUT_W'({vertex_total, path_length, max_y, max_x, min_y, min_x});
	assign m_axis_tuser = status;

endmodule

FILE: sim/path_bounds_and_length_tb.sv
module path_bounds_and_length_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pbl_pkg::*;

	localparam int COORD_W = COORD_BITS_DEF;
	localparam int COUNT_W = COUNT_BITS_DEF;
	localparam int IN_W = ((2*COORD_W+7)/8)*8;
	localparam int SUM_W = 4*COORD_W + LEN_BITS + COUNT_W;
	localparam int OUT_W = ((SUM_W+7)/8)*8;

	localparam logic [CFG_ADDR_BITS-1:0] ADDR_CLOSED_PATH = CFG_ADDR_BITS'(4*CFG_IDX_CLOSED_PATH);
	localparam logic [CFG_ADDR_BITS-1:0] ADDR_SPARE = CFG_ADDR_BITS'(4);

	localparam longint unsigned LEN_MAX = (64'd1 << LEN_BITS) - 64'd1;
	localparam int SETTLE_CYCLES = 2*COORD_W + 32;
	localparam int RANDOM_ITEMS = 1200;
	localparam int LONG_VERTICES = 64;
	localparam int CYCLE_LIMIT = 6_000_000;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

	// one result beat: tuser on top of the used tdata bits
	typedef struct packed {
		pbl_status_t          status;
		logic [COUNT_W-1:0]   vertex_total;
		logic [LEN_BITS-1:0]  path_length;
		coord_t               max_y;
		coord_t               max_x;
		coord_t               min_y;
		coord_t               min_x;
	} path_summary_t;

	typedef enum {RDY_OPEN, RDY_COIN, RDY_HELD} ready_mode_t;

	logic clk;
	logic arst_n = 1'b0;

	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	// x_coord, y_coord
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             s_axis_tlast = 1'b0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	// min_x, min_y, max_x, max_y, path_length, vertex_total
	logic [OUT_W-1:0] m_axis_tdata;
	// status
	logic [1:0]       m_axis_tuser;

	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [CFG_ADDR_BITS-1:0] paddr = '0;
	logic [CFG_DATA_BITS-1:0] pwdata = '0;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;

	// path tracker state
	logic               mode_closed;
	coord_t             org_x, org_y, tail_x, tail_y;
	coord_t             box_lo_x, box_lo_y, box_hi_x, box_hi_y;
	longint unsigned    perim_acc;
	logic [COUNT_W-1:0] vtx_count;
	logic               perim_clipped;

	path_summary_t pending_summaries[$];
	int mismatches = 0;
	int burst_left = 0;
	int cycle_count = 0;
	int ready_left = 0;
	ready_mode_t ready_mode = RDY_OPEN;

	path_bounds_and_length u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// restoring square root, two radicand bits per step
	function automatic longint unsigned isqrt(longint unsigned radicand);
		longint unsigned root = 0;
		longint unsigned rem = 0;
		longint unsigned trial;
		for (int i = 31; i >= 0; i--) begin
			rem = (rem << 2) | ((radicand >> (2*i)) & 64'd3);
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic longint unsigned segment_length(coord_t ax, coord_t ay, coord_t bx,
			coord_t by);
		longint dx, dy;
		dx = longint'(bx) - longint'(ax);
		dy = longint'(by) - longint'(ay);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		return isqrt($unsigned(dx*dx) + $unsigned(dy*dy));
	endfunction

	// saturating perimeter sum with sticky clip flag
	function automatic void add_segment(longint unsigned seg);
		longint unsigned total;
		total = perim_acc + seg;
		if (total > LEN_MAX) begin
			total = LEN_MAX;
			perim_clipped = 1'b1;
		end
		perim_acc = total;
	endfunction

	function automatic void start_new_path();
		org_x = '0;
		org_y = '0;
		tail_x = '0;
		tail_y = '0;
		box_lo_x = '0;
		box_lo_y = '0;
		box_hi_x = '0;
		box_hi_y = '0;
		perim_acc = 0;
		vtx_count = '0;
		perim_clipped = 1'b0;
	endfunction

	// fold one accepted vertex into the path, queue the summary on the final one
	function automatic void trace_vertex(coord_t x, coord_t y, logic last);
		path_summary_t s;
		if (vtx_count == '0) begin
			org_x = x;
			org_y = y;
			box_lo_x = x;
			box_hi_x = x;
			box_lo_y = y;
			box_hi_y = y;
		end else begin
			add_segment(segment_length(tail_x, tail_y, x, y));
			if (x < box_lo_x) box_lo_x = x;
			if (x > box_hi_x) box_hi_x = x;
			if (y < box_lo_y) box_lo_y = y;
			if (y > box_hi_y) box_hi_y = y;
		end
		tail_x = x;
		tail_y = y;
		if (vtx_count != '1) vtx_count++;
		if (!last) return;

		if (mode_closed) add_segment(segment_length(x, y, org_x, org_y));
		s.min_x = box_lo_x;
		s.min_y = box_lo_y;
		s.max_x = box_hi_x;
		s.max_y = box_hi_y;
		s.path_length = perim_acc[LEN_BITS-1:0];
		s.vertex_total = vtx_count;
		if (vtx_count < (mode_closed ? 3 : 2))
			s.status = STATUS_TOO_FEW;
		else if (perim_clipped)
			s.status = STATUS_LEN_SAT;
		else
			s.status = STATUS_OK;
		pending_summaries = {pending_summaries, s};
		start_new_path();
	endfunction

	function automatic void field_check(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_summary();
		path_summary_t want, got;
		got = {m_axis_tuser, m_axis_tdata[SUM_W-1:0]};
		if (pending_summaries.size() == 0) begin
			$display("%0t: result beat with no path pending, got %0h", $time, got);
			mismatches++;
			return;
		end
		want = pending_summaries.pop_front();
		field_check("min_x", want.min_x, got.min_x);
		field_check("min_y", want.min_y, got.min_y);
		field_check("max_x", want.max_x, got.max_x);
		field_check("max_y", want.max_y, got.max_y);
		field_check("path_length", want.path_length, got.path_length);
		field_check("vertex_total", want.vertex_total, got.vertex_total);
		field_check("status", want.status, got.status);
	endfunction

	// result checking, receiver stall pattern and run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) check_summary();
		if (ready_left == 0) begin
			case ($urandom_range(0, 3))
				0, 1: ready_mode = RDY_OPEN;
				2: ready_mode = RDY_COIN;
				default: ready_mode = RDY_HELD;
			endcase
			ready_left = (ready_mode == RDY_HELD) ? $urandom_range(1, 30) : $urandom_range(1, 60);
		end else begin
			ready_left--;
		end
		case (ready_mode)
			RDY_OPEN: m_axis_tready <= 1'b1;
			RDY_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
			default: m_axis_tready <= 1'b0;
		endcase
	end

	// register write: setup beat then access beat
	task automatic cfg_write(input logic [CFG_ADDR_BITS-1:0] addr,
			input logic [CFG_DATA_BITS-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_CLOSED_PATH) mode_closed = data[0];
	endtask

	// one vertex beat, with bursts and random gaps on the sender side
	task automatic send_vertex(input coord_t x, input coord_t y, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) :
				$urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_W'({y, x});
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		trace_vertex(x, y, last);
		burst_left--;
	endtask

	// stop sending and let every pending summary come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_summaries.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 4))
			0, 1: return coord_t'($urandom);
			2: return coord_t'(int'($urandom_range(0, 512)) - 256);
			3: return coord_t'(int'($urandom_range(0, 65536)) - 32768);
			default: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
		endcase
	endfunction

	// reset value is closed polygon: triangle, single point, too-short path, extreme box
	task automatic test_closed_defaults();
		send_vertex(0, 0, 1'b0);
		send_vertex(768, 0, 1'b0);
		send_vertex(0, 1024, 1'b1);
		send_vertex(COORD_MAX, COORD_MIN, 1'b1);
		send_vertex(COORD_MIN, COORD_MIN, 1'b0);
		send_vertex(COORD_MAX, COORD_MAX, 1'b1);
		send_vertex(COORD_MIN, COORD_MIN, 1'b0);
		send_vertex(COORD_MAX, COORD_MIN, 1'b0);
		send_vertex(COORD_MAX, COORD_MAX, 1'b0);
		send_vertex(COORD_MIN, COORD_MAX, 1'b1);
		drain();
	endtask

	// open broken line: one point is too few, two are enough
	task automatic test_open_paths();
		cfg_write(ADDR_CLOSED_PATH, 32'd0);
		send_vertex(0, 0, 1'b1);
		send_vertex(-1, -1, 1'b0);
		send_vertex(1, 1, 1'b1);
		send_vertex(COORD_MIN, 12345, 1'b0);
		send_vertex(-6789, COORD_MAX, 1'b0);
		send_vertex(COORD_MAX, COORD_MIN, 1'b1);
		drain();
	endtask

	// mode is taken when the final vertex arrives
	task automatic test_mode_switch_mid_path();
		send_vertex(100, -200, 1'b0);
		send_vertex(-300, 400, 1'b0);
		drain();
		cfg_write(ADDR_CLOSED_PATH, 32'd1);
		send_vertex(5, 5, 1'b1);
		drain();
	endtask

	// writes beyond the closed_path register change nothing
	task automatic test_spare_register();
		cfg_write(ADDR_SPARE, 32'd0);
		send_vertex(10, 10, 1'b0);
		send_vertex(20, -20, 1'b0);
		send_vertex(-30, 30, 1'b1);
		drain();
	endtask

	// long closed path between opposite corners, largest segments back to back
	task automatic test_long_corner_path();
		for (int i = 0; i < LONG_VERTICES; i++)
			send_vertex((i % 2) ? COORD_MAX : COORD_MIN, (i % 2) ? COORD_MAX : COORD_MIN,
				i == LONG_VERTICES - 1);
		drain();
		// next path starts from a clean sum
		send_vertex(0, 0, 1'b0);
		send_vertex(256, 0, 1'b0);
		send_vertex(0, 256, 1'b1);
		drain();
	endtask

	// random paths, mostly short, in both modes
	task automatic test_random_paths();
		int sent, n;
		for (int p = 0; p < 4; p++) begin
			cfg_write(ADDR_CLOSED_PATH, (p % 2 == 0) ? 32'd0 : 32'd1);
			sent = 0;
			while (sent < RANDOM_ITEMS/4) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
				for (int v = 0; v < n; v++)
					send_vertex(rand_coord(), rand_coord(), v == n - 1);
				sent += n;
			end
			drain();
		end
	endtask

	initial begin
		mode_closed = 1'b1;
		start_new_path();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_closed_defaults();
		test_open_paths();
		test_mode_switch_mid_path();
		test_spare_register();
		test_long_corner_path();
		test_random_paths();

		drain();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
rtl/pbl_pkg.sv
rtl/pbl_isqrt.sv
rtl/pbl_dp.sv
rtl/pbl_ctrl.sv
rtl/path_bounds_and_length.sv
sim/path_bounds_and_length_tb.sv
